// ----- hdl/rau_pkg.sv -----
package rau_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CAP_BITS      = 63;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 63'd1000000000;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_WORD = 2'd2,
        ST_CAP  = 2'd3
    } status_t;

    // command from controller to datapath
    typedef struct packed {
        logic load;     // capture operands
        logic mul_a;    // first cross product
        logic mul_b;    // second cross product
        logic mul_d;    // denominator product
        logic combine;  // signed sum or select
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic div_next; // move quotient into numerator, start denominator
        logic finish;   // range checks and result register
    } dp_cmd_t;

    typedef struct packed {
        logic mul_last; // last partial product of a 64x64 product
        logic gcd_done;
        logic div_last;
        logic early_div0;
        logic num_zero;
    } dp_stat_t;

endpackage

// ----- hdl/rau_datapath.sv -----
module rau_datapath
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  dp_cmd_t              cmd_i,
    output dp_stat_t             stat,
    input  logic [1:0]           op,
    input  logic [63:0]          a_num,
    input  logic [62:0]          a_den,
    input  logic [63:0]          b_num,
    input  logic [62:0]          b_den,
    input  logic [CAP_BITS-1:0]  max_abs,
    output logic [63:0]          res_num,
    output logic [62:0]          res_den,
    output logic [1:0]           status
);

    localparam logic [63:0] LIMIT = 64'd1 << (WORD_BITS - 1);

    logic [1:0]   op_reg;
    logic [63:0]  amag_reg, bmag_reg;
    logic [62:0]  ad_reg, bd_reg;
    logic         aneg_reg, bneg_reg;
    logic [127:0] t1_reg, t2_reg, den_reg;
    logic         t2neg_eff;
    logic [127:0] nm_reg, dm_reg;      // numerator and denominator magnitudes
    logic         nneg_reg, dneg_reg;
    logic [127:0] ga_reg, gb_reg;
    logic [7:0]   gk_reg;
    logic         godd_reg;            // a made odd
    logic [127:0] q_reg, r_reg, dv_reg, g_reg;
    logic [6:0]   cnt_reg;
    logic         which_reg;           // 0 numerator, 1 denominator
    logic [1:0]   mcnt_reg;            // partial product index
    logic [127:0] macc_reg;

    logic [63:0]  m_x, m_y;
    logic [31:0]  m_xh, m_yh;
    logic [63:0]  m_pp;
    logic [127:0] m_term, m_acc_next;
    logic         m_any, m_last;
    logic [127:0] r_sh, r_sub;
    logic         r_ge;

    always_comb
    begin
        m_x = amag_reg;
        m_y = {1'b0, bd_reg};
        if (cmd_i.mul_b)
        begin
            m_x = bmag_reg;
            m_y = {1'b0, ad_reg};
        end
        if (cmd_i.mul_d)
        begin
            m_x = {1'b0, ad_reg};
            m_y = (op_reg == CMD_DIV) ? bmag_reg : {1'b0, bd_reg};
        end
        if (cmd_i.mul_a && op_reg == CMD_MUL)
            m_y = bmag_reg;
    end

    // 64x64 product as four 32x32 partial products, one per cycle
    always_comb
    begin
        m_xh = mcnt_reg[1] ? m_x[63:32] : m_x[31:0];
        m_yh = mcnt_reg[0] ? m_y[63:32] : m_y[31:0];
        m_pp = m_xh * m_yh;
        case (mcnt_reg)
            2'd0:    m_term = {64'd0, m_pp};
            2'd3:    m_term = {m_pp, 64'd0};
            default: m_term = {32'd0, m_pp, 32'd0};
        endcase
        m_acc_next = ((mcnt_reg == 2'd0) ? 128'd0 : macc_reg) + m_term;
    end

    assign m_any  = cmd_i.mul_a || cmd_i.mul_b || cmd_i.mul_d;
    assign m_last = (mcnt_reg == 2'd3);

    assign t2neg_eff = ((op_reg == CMD_SUB) ? ~bneg_reg : bneg_reg) && (t2_reg != '0);

    assign r_sh  = {r_reg[126:0], which_reg ? dm_reg[cnt_reg] : nm_reg[cnt_reg]};
    assign r_ge  = r_sh >= g_reg;
    assign r_sub = r_sh - g_reg;

    assign stat.mul_last   = m_last;
    assign stat.gcd_done   = godd_reg && (gb_reg == '0);
    assign stat.div_last   = (cnt_reg == 7'd0);
    assign stat.early_div0 = (op_reg == CMD_DIV && bmag_reg == '0) || den_reg == '0;
    assign stat.num_zero   = (nm_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            op_reg    <= op;
            aneg_reg  <= a_num[63];
            bneg_reg  <= b_num[63];
            amag_reg  <= a_num[63] ? (~a_num + 64'd1) : a_num;
            bmag_reg  <= b_num[63] ? (~b_num + 64'd1) : b_num;
            ad_reg    <= a_den;
            bd_reg    <= b_den;
            mcnt_reg  <= '0;
            which_reg <= 1'b0;
        end
        if (m_any)
        begin
            macc_reg <= m_acc_next;
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (cmd_i.mul_a && m_last)
            t1_reg <= m_acc_next;
        if (cmd_i.mul_b && m_last)
            t2_reg <= m_acc_next;
        if (cmd_i.mul_d && m_last)
            den_reg <= m_acc_next;
        if (cmd_i.combine)
        begin
            dm_reg   <= den_reg;
            dneg_reg <= (op_reg == CMD_DIV) && bneg_reg && den_reg != '0;
            if (op_reg == CMD_ADD || op_reg == CMD_SUB)
            begin
                if (aneg_reg == t2neg_eff)
                begin
                    nm_reg   <= t1_reg + t2_reg;
                    nneg_reg <= aneg_reg;
                end
                else if (t1_reg >= t2_reg)
                begin
                    nm_reg   <= t1_reg - t2_reg;
                    nneg_reg <= aneg_reg && t1_reg != t2_reg;
                end
                else
                begin
                    nm_reg   <= t2_reg - t1_reg;
                    nneg_reg <= t2neg_eff;
                end
            end
            else
            begin
                nm_reg   <= t1_reg;
                nneg_reg <= ((op_reg == CMD_MUL) ? (aneg_reg ^ bneg_reg) : aneg_reg)
                            && t1_reg != '0;
            end
        end
        if (cmd_i.gcd_init)
        begin
            ga_reg   <= nm_reg;
            gb_reg   <= dm_reg;
            gk_reg   <= '0;
            godd_reg <= 1'b0;
        end
        if (cmd_i.gcd_step)
        begin
            // one binary gcd step per cycle
            if (!godd_reg)
            begin
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    gk_reg <= gk_reg + 8'd1;
                end
                else if (!ga_reg[0])
                    ga_reg <= ga_reg >> 1;
                else
                    godd_reg <= 1'b1;
            end
            else if (!gb_reg[0])
                gb_reg <= gb_reg >> 1;
            else if (ga_reg > gb_reg)
            begin
                ga_reg <= gb_reg;
                gb_reg <= ga_reg - gb_reg;
            end
            else
                gb_reg <= gb_reg - ga_reg;
        end
        if (cmd_i.div_init)
        begin
            g_reg     <= ga_reg << gk_reg[6:0];
            r_reg     <= '0;
            q_reg     <= '0;
            cnt_reg   <= 7'd127;
            which_reg <= 1'b0;
        end
        if (cmd_i.div_step)
        begin
            r_reg   <= r_ge ? r_sub : r_sh;
            q_reg   <= {q_reg[126:0], r_ge};
            cnt_reg <= cnt_reg - 7'd1;
        end
        if (cmd_i.div_next)
        begin
            nm_reg    <= q_reg;
            r_reg     <= '0;
            q_reg     <= '0;
            cnt_reg   <= 7'd127;
            which_reg <= 1'b1;
        end
        if (cmd_i.finish)
        begin
            res_num <= '0;
            res_den <= 63'd1;
            if (stat.early_div0)
                status <= ST_DIV0;
            else
            begin
                logic [127:0] fn, fd;
                logic         fneg;
                fn   = nm_reg;
                fd   = which_reg ? q_reg : 128'd1;
                fneg = which_reg && (nneg_reg != dneg_reg);
                if (fn[127:64] != '0 || fd[127:64] != '0 ||
                    fn[63:0] > (fneg ? LIMIT : LIMIT - 64'd1) ||
                    fd[63:0] > LIMIT - 64'd1)
                    status <= ST_WORD;
                else if (fn[63:0] > {1'b0, max_abs} || fd[63:0] > {1'b0, max_abs})
                    status <= ST_CAP;
                else
                begin
                    status  <= ST_OK;
                    res_num <= fneg ? (~fn[63:0] + 64'd1) : fn[63:0];
                    res_den <= fd[62:0];
                end
            end
        end
    end

endmodule

// ----- hdl/rau_ctrl.sv -----
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    output logic     busy,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd_o
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MULA  = 10'b0000000010,
        S_MULB  = 10'b0000000100,
        S_MULD  = 10'b0000001000,
        S_COMB  = 10'b0000010000,
        S_GINIT = 10'b0000100000,
        S_GCD   = 10'b0001000000,
        S_DIVN  = 10'b0010000000,
        S_DIVD  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   divd_started_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !out_ready;
        cmd_o      = '0;
        cmd_o.load = in_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd_o.mul_a = 1'b1;
                if (stat.mul_last)
                    state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd_o.mul_b = 1'b1;
                if (stat.mul_last)
                    state_next = S_MULD;
            end
            S_MULD:
            begin
                cmd_o.mul_d = 1'b1;
                if (stat.mul_last)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd_o.combine = 1'b1;
                state_next    = S_GINIT;
            end
            S_GINIT:
            begin
                if (stat.early_div0 || stat.num_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd_o.gcd_init = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd_o.div_init = 1'b1;
                    state_next = S_DIVN;
                end
                else
                    cmd_o.gcd_step = 1'b1;
            end
            S_DIVN:
            begin
                cmd_o.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_DIVD;
            end
            S_DIVD:
            begin
                if (!divd_started_reg)
                    cmd_o.div_next = 1'b1;
                else
                begin
                    cmd_o.div_step = 1'b1;
                    if (stat.div_last)
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd_o.finish = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // denominator pass: first cycle in S_DIVD moves quotient, then 128 steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divd_started_reg <= 1'b0;
        else if (state_reg == S_DIVN && stat.div_last)
            divd_started_reg <= 1'b0;
        else if (state_reg == S_DIVD)
            divd_started_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = valid_reg;

endmodule

// ----- hdl/rational_arith_unit.sv -----
// rational_arith_unit: exact fraction add, subtract, multiply and divide
//
// input channel: in_valid/in_ready with cmd, a_num/a_den, b_num/b_den; a
// transaction is taken only while the sequencer is idle
// output channel: out_valid/out_ready with res_num, res_den, status; the
// result sits in an output register, so the next input transaction is taken
// while a finished result still waits for the receiver
// configuration: APB write of max_abs at byte address 0, pready tied high
//
// sequence per transaction: three products through one 32x32 multiplier
// (four partial products each), then sign handling, then the binary
// gcd (one shift or subtract per cycle), then two restoring divisions by
// the gcd, numerator first and then denominator, then the range checks;
// zero numerator and divide by zero skip the gcd and divisions
//
// reset clears the sequencer and the output valid flag and loads max_abs
// with 1000000000; if the receiver stalls, a finished item waits in the
// sequencer's last state until the output register is free
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [63:0] a_num,
    input  logic [62:0] a_den,
    input  logic [63:0] b_num,
    input  logic [62:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] res_num,
    output logic [62:0] res_den,
    output logic [1:0]  status
);

    localparam logic [2:0] ADDR_MAX_ABS = 3'd0;

    logic [CAP_BITS-1:0] max_abs_reg;
    logic                busy;
    logic                in_fire;
    dp_cmd_t             dcmd;
    dp_stat_t            dstat;

    assign pready = 1'b1;
    // cap register, written on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_abs_reg <= CAP_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MAX_ABS)
            max_abs_reg <= pwdata[CAP_BITS-1:0];
    end
    assign prdata = (paddr == ADDR_MAX_ABS) ? {1'b0, max_abs_reg} : '0;

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dstat),
        .cmd_o     (dcmd)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk     (clk),
        .cmd_i   (dcmd),
        .stat    (dstat),
        .op      (cmd),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .max_abs (max_abs_reg),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result of the fraction unit
    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        status_t     st;
    } fraction_t;

    // in-order store of predicted fractions, compared against each output transaction
    class fraction_board;
        fraction_t pending[$];
        int        errors;

        function void note(fraction_t f);
            pending = {pending, f};
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [63:0] num, logic [62:0] den, logic [1:0] st);
            fraction_t f;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %0d/%0d status %0d", $signed(num), den, st));
            end
            else
            begin
                f = pending.pop_front();
                if (num !== f.num)
                    report($sformatf("res_num %0d expected %0d", $signed(num), $signed(f.num)));
                if (den !== f.den)
                    report($sformatf("res_den %0d expected %0d", den, f.den));
                if (st !== f.st)
                    report($sformatf("status %0d expected %0d", st, f.st));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_ADD;
    logic [63:0] a_num = '0;
    logic [62:0] a_den = 63'd1;
    logic [63:0] b_num = '0;
    logic [62:0] b_den = 63'd1;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  status;

    fraction_board board = new();

    // testbench copy of the cap register
    logic [62:0] cap_val = CAP_RESET;
    // idle percentage for sender and receiver, zero for a quiet stretch
    int          idle_pct = 27;
    // receiver hold-off, counted down in the receiver process
    int          rx_hold = 0;

    localparam logic [129:0] WORD_MAX = 130'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]   ADDR_MAX_ABS = 3'd0;

    always #2 clk = ~clk;

    rational_arith_unit u_dut (.*);

    function automatic logic [129:0] gcd130(logic [129:0] x, logic [129:0] y);
        logic [129:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // exact fraction result with reduction, range and cap checks
    function automatic fraction_t reduce_fraction(cmd_t op, logic [63:0] an, logic [62:0] ad,
                                                  logic [63:0] bn, logic [62:0] bd);
        logic signed [129:0] sa, sb, da, db, num, den;
        logic [129:0]        nm, dm, g;
        logic                rneg;
        fraction_t           f;
        sa = $signed({{66{an[63]}}, an});
        sb = $signed({{66{bn[63]}}, bn});
        da = $signed({67'd0, ad});
        db = $signed({67'd0, bd});
        case (op)
            CMD_ADD:
            begin
                num = sa * db + sb * da;
                den = da * db;
            end
            CMD_SUB:
            begin
                num = sa * db - sb * da;
                den = da * db;
            end
            CMD_MUL:
            begin
                num = sa * sb;
                den = da * db;
            end
            default:
            begin
                num = sa * db;
                den = da * sb;
            end
        endcase
        f.num = '0;
        f.den = 63'd1;
        f.st  = ST_OK;
        // zero divisor and zero input denominators both give a zero product denominator
        if (den == 0)
        begin
            f.st = ST_DIV0;
            return f;
        end
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        rneg = 1'b0;
        if (nm != 0)
        begin
            g    = gcd130(nm, dm);
            nm   = nm / g;
            dm   = dm / g;
            rneg = (num < 0) != (den < 0);
        end
        else
        begin
            dm = 130'd1;
        end
        // the most negative word value is in range but always exceeds the cap
        if (nm > (rneg ? WORD_MAX + 1 : WORD_MAX) || dm > WORD_MAX)
            f.st = ST_WORD;
        else if (nm > {67'd0, cap_val} || dm > {67'd0, cap_val})
            f.st = ST_CAP;
        else
        begin
            f.num = rneg ? -nm[63:0] : nm[63:0];
            f.den = dm[62:0];
        end
        return f;
    endfunction

    // receiver: check accepted results, random or forced back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check(res_num, res_den, status);
            if (rx_hold > 0)
            begin
                rx_hold   <= rx_hold - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= $urandom_range(99) >= idle_pct;
            end
        end
    end

    // one input transaction; valid stays high between back-to-back items
    task send_item(cmd_t op, logic [63:0] an, logic [62:0] ad, logic [63:0] bn,
                   logic [62:0] bd);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        do @(posedge clk); while (!in_ready);
        board.note(reduce_fraction(op, an, ad, bn, bd));
    endtask

    task drain;
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // cap write only while idle: every earlier transaction has already returned
    task write_cap(logic [62:0] v);
        drain();
        repeat (10) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_ABS;
        pwdata  <= {1'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_val  = v;
    endtask

    function automatic logic [63:0] pick_num();
        int m;
        m = $urandom_range(99);
        if (m < 55) return 64'($signed($urandom_range(2000)) - 1000);
        if (m < 65) return '0;
        if (m < 75) return 64'($signed($urandom_range(2000000)) - 1000000);
        if (m < 80) return {1'b1, 63'd0};
        if (m < 83) return {1'b0, {63{1'b1}}};
        return {$urandom, $urandom};
    endfunction

    function automatic logic [62:0] pick_den();
        int m;
        m = $urandom_range(99);
        if (m < 60) return 63'($urandom_range(1000, 1));
        if (m < 70) return 63'($urandom_range(1000000, 1));
        if (m < 73) return '0;
        if (m < 77) return {63{1'b1}};
        return 63'({$urandom, $urandom});
    endfunction

    localparam logic [63:0] NUM_MIN = {1'b1, 63'd0};
    localparam logic [63:0] NUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic [62:0] DEN_MAX = {63{1'b1}};

    initial
    begin
        int   n;
        cmd_t op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation, zero divisor, zero denominators, range and cap edges
        send_item(CMD_ADD, 64'd1, 63'd2, 64'd1, 63'd3);
        send_item(CMD_SUB, 64'd1, 63'd2, 64'd1, 63'd2);
        send_item(CMD_MUL, -64'sd6, 63'd4, 64'd2, 63'd9);
        send_item(CMD_DIV, 64'd3, 63'd4, -64'sd9, 63'd8);
        send_item(CMD_DIV, 64'd5, 63'd7, 64'd0, 63'd3);
        send_item(CMD_ADD, 64'd5, 63'd0, 64'd1, 63'd3);
        send_item(CMD_MUL, 64'd5, 63'd2, 64'd1, 63'd0);
        send_item(CMD_MUL, NUM_MAX, 63'd1, NUM_MAX, 63'd1);
        send_item(CMD_ADD, NUM_MAX, 63'd1, NUM_MAX, 63'd1);
        send_item(CMD_SUB, NUM_MIN, 63'd1, NUM_MIN, 63'd1);
        send_item(CMD_MUL, NUM_MIN, 63'd1, 64'd1, 63'd1);
        send_item(CMD_DIV, NUM_MIN, 63'd1, -64'sd1, 63'd1);
        send_item(CMD_ADD, 64'd1, DEN_MAX, 64'd1, DEN_MAX);
        send_item(CMD_MUL, 64'd1, DEN_MAX, 64'd1, 63'd2);
        send_item(CMD_MUL, 64'd1000000000, 63'd1, 64'd1, 63'd1);
        send_item(CMD_MUL, 64'd1000000001, 63'd1, 64'd1, 63'd1);
        send_item(CMD_DIV, 64'd1, 63'd1000000001, 64'd1, 63'd1);
        send_item(CMD_SUB, NUM_MIN, DEN_MAX, NUM_MAX, 63'd1);
        send_item(CMD_DIV, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);

        // cap of zero rejects even 0/1
        write_cap('0);
        send_item(CMD_SUB, 64'd4, 63'd3, 64'd4, 63'd3);
        send_item(CMD_MUL, 64'd1, 63'd1, 64'd1, 63'd1);
        send_item(CMD_DIV, 64'd1, 63'd1, 64'd0, 63'd1);

        // random phases over several cap settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_cap(DEN_MAX);
                1: write_cap(CAP_RESET);
                2: write_cap(63'({$urandom, $urandom}) >> $urandom_range(62));
                default: write_cap(63'($urandom_range(50)));
            endcase
            n = ph == 3 ? 100 : 300;
            for (int i = 0; i < n; i++)
            begin
                // quiet stretch with no idling on either side
                idle_pct = (ph == 0 && i >= 50 && i < 150) ? 0 : 27;
                // long receiver hold-off so the block fills and stalls its input
                if (ph == 1 && i == 20) rx_hold = 3000;
                // sender waits for every outstanding result
                if (ph == 2 && i == 150) drain();
                op = cmd_t'($urandom_range(3));
                send_item(op, pick_num(), pick_den(), pick_num(), pick_den());
            end
        end
        idle_pct = 27;

        drain();
        repeat (1000) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rau_datapath.sv
hdl/rau_ctrl.sv
hdl/rational_arith_unit.sv
tb/sv/tb_top.sv
